// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
// Depends on nothing; included by the assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hw/rtl/nafc_pkg.sv -----
// Package for the no-data aware FIR convolution block.
// Holds configuration indexes, the controller state type, the command struct and fixed widths.
`default_nettype none
package nafc_pkg;
    localparam int unsigned SMP_W  = 17;
    localparam int unsigned COEF_W = 16;
    localparam int unsigned CFG_W  = 34;
    localparam int unsigned IDX_W  = 3;

    localparam logic [IDX_W-1:0] REG_TAP_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_CENTER     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MODE       = 3'd2;
    localparam logic [IDX_W-1:0] REG_LINE_WIDTH = 3'd3;
    localparam logic [IDX_W-1:0] REG_NULLS      = 3'd4;
    localparam logic [IDX_W-1:0] REG_CLAMP      = 3'd5;
    localparam logic [IDX_W-1:0] REG_COEF_SEL   = 3'd6;
    localparam logic [IDX_W-1:0] REG_COEF_VAL   = 3'd7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_FINISH,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;   // capture the incoming request and write it
        logic rd_issue; // issue the read for the current tap
        logic mac;      // accumulate the tap whose read data is now valid
        logic finish;   // form the result from the accumulator
    } t_cmd;
endpackage
`default_nettype wire

// ----- hw/rtl/nafc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; used for the sample delay line.
`default_nettype none
module nafc_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 15361
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/nafc_ctrl.sv -----
// Controller state machine: sequences write, tap reads and the result.
// Depends on nafc_pkg.
`default_nettype none
module nafc_ctrl
    import nafc_pkg::*;
#(
    parameter int unsigned MAX_TAPS = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    input  wire [$clog2(MAX_TAPS+1)-1:0] i_taps,
    output logic [$clog2(MAX_TAPS+1)-1:0] o_tap,
    output t_cmd                         o_cmd
);
    localparam int unsigned TW = $clog2(MAX_TAPS + 1);

    t_state r_state, n_state;
    logic [TW-1:0] r_tap, n_tap;
    logic r_mac, n_mac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_tap   <= '0;
            r_mac   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
            r_mac   <= n_mac;
        end
    end

    always_comb begin
        n_state = r_state;
        n_tap   = r_tap;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_state = S_READ;
                n_tap   = '0;
            end
            S_READ: begin
                n_tap = r_tap + 1'b1;
                if (r_tap == i_taps - 1'b1) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_mac) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready      = (r_state == S_IDLE);
        o_out_valid     = (r_state == S_OUT);
        o_tap           = r_tap;
        o_cmd.accept    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd_issue  = (r_state == S_READ);
        o_cmd.mac       = r_mac;
        o_cmd.finish    = (r_state == S_FINISH) && !r_mac;
        n_mac           = (r_state == S_READ);
    end
endmodule
`default_nettype wire

// ----- hw/rtl/nafc_dp.sv -----
// Datapath: configuration registers, delay line, counters and the shared MAC.
// Depends on nafc_pkg and nafc_ram.
`default_nettype none
module nafc_dp
    import nafc_pkg::*;
#(
    parameter int unsigned MAX_TAPS       = 16,
    parameter int unsigned MAX_LINE       = 1024,
    parameter int unsigned COEF_FRAC_BITS = 12
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire [IDX_W-1:0]               i_cfg_idx,
    input  wire [CFG_W-1:0]               i_cfg_data,
    input  wire [SMP_W-1:0]               i_sample,
    input  wire                           i_fol,
    input  wire                           i_fof,
    input  t_cmd                          i_cmd,
    input  wire [$clog2(MAX_TAPS+1)-1:0]  i_tap,
    output logic [$clog2(MAX_TAPS+1)-1:0] o_taps,
    output logic [SMP_W-1:0]              o_pixel,
    output logic                          o_is_null,
    output logic                          o_window_full
);
    localparam int unsigned TW    = $clog2(MAX_TAPS + 1);
    localparam int unsigned CW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int unsigned DEPTH = (MAX_TAPS - 1) * MAX_LINE + 1;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW    = $clog2(MAX_LINE + 1);
    localparam int unsigned PW    = SMP_W + COEF_W;
    localparam int unsigned ACC_W = PW + TW;
    localparam int unsigned BW    = AW + LW + TW;

    logic [4:0]           r_tap_count;
    logic [3:0]           r_center;
    logic [1:0]           r_mode;
    logic [10:0]          r_line_width;
    logic [CFG_W-1:0]     r_nulls;
    logic [CFG_W-1:0]     r_clamp;
    logic [3:0]           r_coef_sel;
    logic signed [COEF_W-1:0] r_coef [MAX_TAPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count  <= 5'd1;
            r_center     <= 4'd0;
            r_mode       <= 2'd2;
            r_line_width <= 11'd1024;
            r_nulls      <= '0;
            r_clamp      <= 34'd4294836224;
            r_coef_sel   <= 4'd0;
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_coef[i] <= (i == 0) ? COEF_W'(1 << COEF_FRAC_BITS) : '0;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TAP_COUNT:  r_tap_count  <= i_cfg_data[4:0];
                REG_CENTER:     r_center     <= i_cfg_data[3:0];
                REG_MODE:       r_mode       <= i_cfg_data[1:0];
                REG_LINE_WIDTH: r_line_width <= i_cfg_data[10:0];
                REG_NULLS:      r_nulls      <= i_cfg_data;
                REG_CLAMP:      r_clamp      <= i_cfg_data;
                REG_COEF_SEL:   r_coef_sel   <= i_cfg_data[3:0];
                REG_COEF_VAL: begin
                    if (32'(r_coef_sel) < MAX_TAPS) begin
                        r_coef[CW'(r_coef_sel)] <= i_cfg_data[COEF_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // Effective settings after range fixes.
    logic [TW-1:0] w_taps, w_ctr;
    logic [LW-1:0] w_lw;
    logic          w_vert, w_strict;
    always_comb begin
        if (r_tap_count == '0) w_taps = TW'(1);
        else if (32'(r_tap_count) > MAX_TAPS) w_taps = TW'(MAX_TAPS);
        else w_taps = TW'(r_tap_count);
        if (32'(r_center) >= 32'(w_taps)) w_ctr = w_taps - 1'b1;
        else w_ctr = TW'(r_center);
        if (r_line_width == '0) w_lw = LW'(1);
        else if (32'(r_line_width) > MAX_LINE) w_lw = LW'(MAX_LINE);
        else w_lw = LW'(r_line_width);
        w_vert   = r_mode[0];
        w_strict = r_mode[1];
    end
    assign o_taps = w_taps;

    // Capture request, pointer and line/frame counters.
    logic [AW-1:0] r_wp;
    logic [TW-1:0] r_sil, r_lif;
    logic [SMP_W-1:0] r_smp;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_sil <= '0;
            r_lif <= '0;
        end else if (i_cmd.accept) begin
            if (i_fof) begin
                r_sil <= TW'(1);
                r_lif <= TW'(1);
            end else if (i_fol) begin
                r_sil <= TW'(1);
                if (32'(r_lif) < MAX_TAPS) r_lif <= r_lif + 1'b1;
            end else if (32'(r_sil) < MAX_TAPS) begin
                r_sil <= r_sil + 1'b1;
            end
        end else if (i_cmd.finish) begin
            r_wp <= (32'(r_wp) == DEPTH - 1) ? '0 : r_wp + 1'b1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_smp <= i_sample;
    end

    // Read address of the current tap: wp - (taps-1-k)*stride, modulo depth.
    logic [BW-1:0] w_back, w_addr;
    logic [TW-1:0] w_dist;
    always_comb begin
        w_dist = w_taps - 1'b1 - i_tap;
        w_back = w_vert ? BW'(w_dist) * BW'(w_lw) : BW'(w_dist);
        if (w_back > BW'(r_wp)) w_addr = BW'(r_wp) + BW'(DEPTH) - w_back;
        else w_addr = BW'(r_wp) - w_back;
    end

    // The write happens in the cycle after accept, before the first read.
    logic r_we;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_we <= 1'b0;
        else r_we <= i_cmd.accept;
    end

    logic [SMP_W-1:0] w_rdata;
    nafc_ram #(.WIDTH(SMP_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (r_we),
        .i_waddr(r_wp),
        .i_wdata(r_smp),
        .i_raddr(w_addr[AW-1:0]),
        .o_rdata(w_rdata)
    );

    // Tap index of the data now coming out of the memory.
    logic [TW-1:0] r_rtap;
    always_ff @(posedge i_clk) begin
        r_rtap <= i_tap;
    end

    logic signed [ACC_W-1:0] r_acc;
    logic                    r_nul;
    logic signed [PW-1:0]    w_prod;
    logic                    w_tnull;
    assign w_tnull = (w_rdata == r_nulls[SMP_W-1:0]);
    assign w_prod  = $signed(r_coef[CW'(r_rtap)]) * $signed(w_rdata);

    always_ff @(posedge i_clk) begin
        if (r_we) begin
            r_acc <= '0;
            r_nul <= 1'b0;
        end else if (i_cmd.mac) begin
            if (w_tnull) begin
                if (r_rtap == w_ctr || w_strict) r_nul <= 1'b1;
            end else begin
                r_acc <= r_acc + ACC_W'(w_prod);
            end
        end
    end

    // Null value if flagged, else clamp, then truncate toward zero.
    logic signed [SMP_W-1:0]  w_hi, w_lo;
    logic signed [ACC_W-1:0]  w_hi_s, w_lo_s, w_adj;
    logic [SMP_W-1:0]         w_res;
    always_comb begin
        w_lo   = r_clamp[SMP_W-1:0];
        w_hi   = r_clamp[2*SMP_W-1:SMP_W];
        w_hi_s = ACC_W'(w_hi) <<< COEF_FRAC_BITS;
        w_lo_s = ACC_W'(w_lo) <<< COEF_FRAC_BITS;
        w_adj  = r_acc[ACC_W-1] ? r_acc + ACC_W'((1 << COEF_FRAC_BITS) - 1) : r_acc;
        if (r_nul) w_res = r_nulls[2*SMP_W-1:SMP_W];
        else if (r_acc > w_hi_s) w_res = w_hi;
        else if (r_acc < w_lo_s) w_res = w_lo;
        else w_res = w_adj[COEF_FRAC_BITS +: SMP_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_pixel       <= w_res;
            o_is_null     <= r_nul;
            o_window_full <= (w_vert ? r_lif : r_sil) >= w_taps;
        end
    end
endmodule
`default_nettype wire

// ----- hw/rtl/nodata_aware_fir_convolution_top.sv -----
// Strided FIR convolution with no-data handling, one raster sample a request.
// Input request on s_axis: tdata = sample[16:0]; tuser = {first_of_frame,
// first_of_line} (first_of_line in bit 0). Result on m_axis: tdata =
// pixel[16:0], zero-filled to 24 bits; tuser = {window_full, is_null}.
// Configuration is a write-only port: i_cfg_we, i_cfg_index, i_cfg_data,
// to be written only while the block is idle; the block does not enforce this.
// One request is processed at a time. After acceptance, a request goes through
// the write, one delay-line read per tap through the single memory read port,
// a drain step and the forming of the result before the result is valid. The
// next request is accepted the cycle after the result is taken.
// If the receiver stalls, the result is held and no new request is taken.
// Synchronous reset restores the register defaults and clears the pointer and
// line/frame counters; the delay line is not cleared and needs no sweep.
`default_nettype none
module nodata_aware_fir_convolution_top
    import nafc_pkg::*;
#(
    parameter int unsigned MAX_TAPS       = 16,
    parameter int unsigned MAX_LINE       = 1024,
    parameter int unsigned COEF_FRAC_BITS = 12
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire  [23:0]       s_axis_tdata,  // sample[16:0]
    input  wire  [1:0]        s_axis_tuser,  // first_of_line, first_of_frame
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [23:0]       m_axis_tdata,  // pixel[16:0]
    output logic [1:0]        m_axis_tuser,  // is_null, window_full
    input  wire               i_cfg_we,
    input  wire  [IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_W-1:0]  i_cfg_data
);
    localparam int unsigned TW = $clog2(MAX_TAPS + 1);

    t_cmd          w_cmd;
    logic [TW-1:0] w_tap, w_taps;
    logic [SMP_W-1:0] w_pixel;
    logic          w_is_null, w_wfull;

    nafc_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_taps     (w_taps),
        .o_tap      (w_tap),
        .o_cmd      (w_cmd)
    );

    nafc_dp #(
        .MAX_TAPS      (MAX_TAPS),
        .MAX_LINE      (MAX_LINE),
        .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_sample     (s_axis_tdata[SMP_W-1:0]),
        .i_fol        (s_axis_tuser[0]),
        .i_fof        (s_axis_tuser[1]),
        .i_cmd        (w_cmd),
        .i_tap        (w_tap),
        .o_taps       (w_taps),
        .o_pixel      (w_pixel),
        .o_is_null    (w_is_null),
        .o_window_full(w_wfull)
    );

    assign m_axis_tdata = {7'd0, w_pixel};
    assign m_axis_tuser = {w_wfull, w_is_null};
endmodule
`default_nettype wire

// ----- hw/rtl/nafc_checker.sv -----
// Port-level checker for the convolution block, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module nafc_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [1:0]  m_axis_tuser
);
    // One request at a time: never ready for input while a result is pending.
    `ASSERT_IMPL(a_excl, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready, "ready with result")
    // An accepted request does not produce a result in the next cycle.
    `ASSERT_NEXT(a_lat, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !m_axis_tvalid,
        "result too early")
    // A stalled result holds its payload.
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed")
    // Padding bits stay zero.
    `ASSERT_IMPL(a_pad, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[23:17] == 7'd0,
        "padding set")
endmodule

bind nodata_aware_fir_convolution_top nafc_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
`default_nettype wire
